// ===== hw/rtl/peht_pkg.sv =====
// shared types and constants for the polygon edge hit test
`default_nettype none
package peht_pkg;

	localparam int COORD_BITS = 16;
	// edge vector and click offset, one bit wider than a coordinate
	localparam int DIFF_BITS = COORD_BITS + 1;
	// squared length and partial dot products
	localparam int SQ_BITS = 2 * DIFF_BITS;
	// sum of the two signed partial dot products
	localparam int NUM_BITS = SQ_BITS + 1;
	// foot offset quotient, bounded by the edge component magnitude
	localparam int QUO_BITS = DIFF_BITS;
	localparam int PROD_BITS = SQ_BITS + QUO_BITS;
	localparam int CNT_BITS = $clog2(QUO_BITS);
	// foot minus click, per axis
	localparam int OFF_BITS = QUO_BITS + 2;
	localparam int SMALL_BITS = 4;
	localparam int DIST_BITS = 2 * SMALL_BITS;

	localparam int HIT_DIST2 = 10;
	localparam int HIT_REACH = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_X = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_Y = 1'b1;

	// one edge job: edge vector, click offset from its start, closes polygon
	typedef struct packed {
		logic signed [DIFF_BITS-1:0] lx;
		logic signed [DIFF_BITS-1:0] ly;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
		logic                        last;
	} seg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUM,
		BK_CHK,
		BK_PROD,
		BK_DIV,
		BK_RND,
		BK_FIN
	} back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/peht_vertex_if.sv =====
// vertex input channel
`default_nettype none
interface peht_vertex_if import peht_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         final_vertex;

	modport source(output valid, output vertex_x, output vertex_y, output final_vertex,
		input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input final_vertex,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/peht_result_if.sv =====
// hit result output channel
`default_nettype none
interface peht_result_if ();
	logic valid;
	logic ready;
	logic is_hit;

	modport source(output valid, output is_hit, input ready);
	modport sink(input valid, input is_hit, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/peht_cfg_if.sv =====
// configuration write channel
`default_nettype none
interface peht_cfg_if import peht_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [CFG_IDX_BITS-1:0]      index;
	logic signed [COORD_BITS-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/peht_front.sv =====
// front end: click registers, vertex tracking, edge job generation
`default_nettype none
module peht_front import peht_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	peht_vertex_if.sink vertex,
	peht_cfg_if.sink   cfg,
	output logic       push_valid,
	input  wire logic  push_ready,
	output seg_t       push_seg
);

	logic signed [COORD_BITS-1:0] click_x_q, click_y_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                         have_q;
	logic                         pend_open_q, pend_close_q;
	// endpoints of the pending edges
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, old_x_q, old_y_q, cls_x_q, cls_y_q;
	logic                         accept;

	function automatic logic signed [DIFF_BITS-1:0] diff(
		input logic signed [COORD_BITS-1:0] b,
		input logic signed [COORD_BITS-1:0] a
	);
		diff = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
	endfunction

	function automatic seg_t make_seg(
		input logic signed [COORD_BITS-1:0] ax,
		input logic signed [COORD_BITS-1:0] ay,
		input logic signed [COORD_BITS-1:0] bx,
		input logic signed [COORD_BITS-1:0] by,
		input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy,
		input logic                         last
	);
		seg_t s;
		s.lx   = diff(bx, ax);
		s.ly   = diff(by, ay);
		s.dx   = diff(cx, ax);
		s.dy   = diff(cy, ay);
		s.last = last;
		make_seg = s;
	endfunction

	assign cfg.ready    = 1'b1;
	assign vertex.ready = !pend_open_q && !pend_close_q;
	assign accept       = vertex.valid && vertex.ready;

	// open edge goes out before the closing edge
	assign push_valid = pend_open_q || pend_close_q;
	always_comb begin
		if (pend_open_q) begin
			push_seg = make_seg(old_x_q, old_y_q, cur_x_q, cur_y_q, click_x_q, click_y_q, 1'b0);
		end else begin
			push_seg = make_seg(cur_x_q, cur_y_q, cls_x_q, cls_y_q, click_x_q, click_y_q, 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_x_q    <= '0;
			click_y_q    <= '0;
			have_q       <= 1'b0;
			pend_open_q  <= 1'b0;
			pend_close_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_CLICK_X: click_x_q <= cfg.data;
					CFG_CLICK_Y: click_y_q <= cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				pend_open_q  <= have_q;
				pend_close_q <= vertex.final_vertex;
				have_q       <= !vertex.final_vertex;
			end else if (push_valid && push_ready) begin
				if (pend_open_q) begin
					pend_open_q <= 1'b0;
				end else begin
					pend_close_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q  <= vertex.vertex_x;
			cur_y_q  <= vertex.vertex_y;
			old_x_q  <= prev_x_q;
			old_y_q  <= prev_y_q;
			prev_x_q <= vertex.vertex_x;
			prev_y_q <= vertex.vertex_y;
			if (have_q) begin
				cls_x_q <= first_x_q;
				cls_y_q <= first_y_q;
			end else begin
				cls_x_q   <= vertex.vertex_x;
				cls_y_q   <= vertex.vertex_y;
				first_x_q <= vertex.vertex_x;
				first_y_q <= vertex.vertex_y;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/peht_fifo.sv =====
// short edge job queue between front and back
`default_nettype none
module peht_fifo import peht_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire seg_t push_seg,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output seg_t      pop_seg
);

	seg_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push, do_pop;

	assign push_ready = count_q != (FIFO_AW + 1)'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_seg    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_seg;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/peht_back.sv =====
// back end: projection, foot rounding by restoring division, hit accumulation
`default_nettype none
module peht_back import peht_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	input  wire seg_t     pop_seg,
	peht_result_if.source result
);

	localparam logic signed [OFF_BITS-1:0]  REACH_HI = OFF_BITS'(HIT_REACH);
	localparam logic signed [OFF_BITS-1:0]  REACH_LO = -REACH_HI;
	localparam logic signed [DIST_BITS-1:0] DIST_LIM = DIST_BITS'(HIT_DIST2);
	localparam logic [CNT_BITS-1:0]         CNT_LAST = CNT_BITS'(QUO_BITS - 1);

	back_state_t state_q, state_d;

	seg_t                         seg_q;
	logic signed [SQ_BITS-1:0]    sq_x_q, sq_y_q, dot_x_q, dot_y_q;
	logic [SQ_BITS-1:0]           den_q;
	logic signed [NUM_BITS-1:0]   num_q;
	logic                         miss_q, sel_y_q;
	logic [SQ_BITS-1:0]           rem_q;
	logic [QUO_BITS-1:0]          low_q, quo_q, qx_q, qy_q;
	logic [CNT_BITS-1:0]          cnt_q;
	logic                         hit_acc_q;
	logic                         out_valid_q, is_hit_q;

	logic                         miss;
	logic [DIFF_BITS-1:0]         mag;
	logic [PROD_BITS-1:0]         prod;
	logic [SQ_BITS:0]             trial;
	logic                         take;
	logic [QUO_BITS-1:0]          quo_rnd;
	logic signed [OFF_BITS-1:0]   off_x, off_y, foot_x, foot_y;
	logic signed [SMALL_BITS-1:0] sm_x, sm_y;
	logic signed [DIST_BITS-1:0]  dist2;
	logic                         seg_hit, fin_go, load_out;

	// projection ratio outside [0, 1] or degenerate edge
	assign miss = (den_q == '0) || num_q[NUM_BITS-1] ||
		(num_q > $signed({1'b0, den_q}));

	always_comb begin
		if (sel_y_q) begin
			mag = seg_q.ly[DIFF_BITS-1] ? DIFF_BITS'(-seg_q.ly) : seg_q.ly;
		end else begin
			mag = seg_q.lx[DIFF_BITS-1] ? DIFF_BITS'(-seg_q.lx) : seg_q.lx;
		end
	end
	assign prod = PROD_BITS'(num_q[SQ_BITS-1:0]) * PROD_BITS'(mag);

	assign trial   = {rem_q, low_q[QUO_BITS-1]};
	assign take    = trial >= {1'b0, den_q};
	// ties round away from zero
	assign quo_rnd = ({rem_q, 1'b0} >= {1'b0, den_q}) ? quo_q + 1'b1 : quo_q;

	// foot offset from the edge start and from the click, per axis
	assign foot_x = seg_q.lx[DIFF_BITS-1] ? -$signed({2'b00, qx_q}) : $signed({2'b00, qx_q});
	assign foot_y = seg_q.ly[DIFF_BITS-1] ? -$signed({2'b00, qy_q}) : $signed({2'b00, qy_q});
	assign off_x  = foot_x - OFF_BITS'(seg_q.dx);
	assign off_y  = foot_y - OFF_BITS'(seg_q.dy);
	assign sm_x   = off_x[SMALL_BITS-1:0];
	assign sm_y   = off_y[SMALL_BITS-1:0];
	assign dist2  = DIST_BITS'(sm_x) * DIST_BITS'(sm_x) + DIST_BITS'(sm_y) * DIST_BITS'(sm_y);
	assign seg_hit = !miss_q && (off_x <= REACH_HI) && (off_x >= REACH_LO) &&
		(off_y <= REACH_HI) && (off_y >= REACH_LO) && (dist2 < DIST_LIM);

	assign fin_go   = !seg_q.last || !out_valid_q || result.ready;
	assign load_out = (state_q == BK_FIN) && fin_go && seg_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL:  state_d = BK_SUM;
			BK_SUM:  state_d = BK_CHK;
			BK_CHK:  state_d = miss ? BK_FIN : BK_PROD;
			BK_PROD: state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = BK_RND;
				end
			end
			BK_RND:  state_d = sel_y_q ? BK_FIN : BK_PROD;
			BK_FIN: begin
				if (fin_go) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_acc_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_FIN && fin_go) begin
				hit_acc_q <= seg_q.last ? 1'b0 : (hit_acc_q || seg_hit);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			is_hit_q <= hit_acc_q || seg_hit;
		end
		case (state_q)
			BK_IDLE: begin
				seg_q   <= pop_seg;
				sel_y_q <= 1'b0;
			end
			BK_MUL: begin
				sq_x_q  <= SQ_BITS'(seg_q.lx) * SQ_BITS'(seg_q.lx);
				sq_y_q  <= SQ_BITS'(seg_q.ly) * SQ_BITS'(seg_q.ly);
				dot_x_q <= SQ_BITS'(seg_q.dx) * SQ_BITS'(seg_q.lx);
				dot_y_q <= SQ_BITS'(seg_q.dy) * SQ_BITS'(seg_q.ly);
			end
			BK_SUM: begin
				den_q <= sq_x_q + sq_y_q;
				num_q <= NUM_BITS'(dot_x_q) + NUM_BITS'(dot_y_q);
			end
			BK_CHK: begin
				miss_q <= miss;
			end
			BK_PROD: begin
				// upper part is already below the squared length
				rem_q <= prod[PROD_BITS-1:QUO_BITS];
				low_q <= prod[QUO_BITS-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q <= take ? SQ_BITS'(trial - {1'b0, den_q}) : trial[SQ_BITS-1:0];
				quo_q <= {quo_q[QUO_BITS-2:0], take};
				low_q <= {low_q[QUO_BITS-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			BK_RND: begin
				if (sel_y_q) begin
					qy_q <= quo_rnd;
				end else begin
					qx_q <= quo_rnd;
				end
				sel_y_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result.valid  = out_valid_q;
	assign result.is_hit = is_hit_q;

endmodule
`default_nettype wire

// ===== hw/rtl/polygon_edge_hit_test_top.sv =====
// top level of the polygon edge hit test
`default_nettype none
// Polygon edge hit test. Vertices arrive one beat at a time on the vertex
// channel, the last one flagged by final_vertex; the click point is held in
// two configuration registers (index 0 is click_x, index 1 is click_y).
// The user must write them only while the block is idle; the block
// itself does not enforce this. Every edge of the polygon, the closing
// edge included, is tested: the click is projected onto the edge, the
// projection must fall within the edge, the foot point is rounded to the
// nearest integer (ties away from zero), and the edge hits when the
// squared distance from the foot to the click is below 10. On the final
// vertex one result beat gives the OR over all edges; other vertices give
// none. A vertex after the first of its polygon carries one edge, and the
// final vertex adds the closing edge. For an edge that passes the range
// check the back end is bound by the 17-step restoring divider that is
// run once for the x and once for the y foot offset; an edge rejected by
// the range check skips the divider. The front end turns a vertex into
// edge jobs and keeps accepting vertices until the four-entry job queue
// is full, so vertices are taken while earlier edges are still worked on.
// The result sits in an output register, so the back end runs on while a
// finished result waits, stalling only if a second one is ready.
module polygon_edge_hit_test_top import peht_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	peht_vertex_if.sink   vertex,
	peht_cfg_if.sink      cfg,
	peht_result_if.source result
);

	// edge jobs from front to queue
	logic push_valid, push_ready;
	seg_t push_seg;
	// edge jobs from queue to back
	logic pop_valid, pop_ready;
	seg_t pop_seg;

	// vertex tracking, click registers, edge vector setup
	peht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertex     (vertex),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_seg   (push_seg)
	);

	// decouples vertex intake from the long per-edge arithmetic
	peht_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_seg   (push_seg),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_seg    (pop_seg)
	);

	// projection, division, distance check and per-polygon OR
	peht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_seg   (pop_seg),
		.result    (result)
	);

endmodule
`default_nettype wire
